FILE: hdl/qst_pkg.sv
// shared types and constants of the queue and stack transfer engine
package qst_pkg;

    localparam int FUNC_W  = 3;
    localparam int STAT_W  = 2;
    localparam int VALUE_W = 32;

    typedef enum logic [FUNC_W-1:0] {
        FN_ENQ  = 3'd0,
        FN_DEQ  = 3'd1,
        FN_PUSH = 3'd2,
        FN_POP  = 3'd3,
        FN_XFER = 3'd4,
        FN_DUMP = 3'd5
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_status            status;
        logic [VALUE_W-1:0] value;
        logic               from_stack;
        logic               last;
    } t_result;

endpackage

FILE: hdl/qst_in_if.sv
// operation channel: function code and data word
interface qst_in_if import qst_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [FUNC_W-1:0]         func;
    logic signed [VALUE_W-1:0] data_value;

    modport source (output valid, output func, output data_value, input ready);
    modport sink   (input valid, input func, input data_value, output ready);
endinterface

FILE: hdl/qst_out_if.sv
// result channel: status, value, origin and last marker
interface qst_out_if import qst_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [STAT_W-1:0]         status;
    logic signed [VALUE_W-1:0] out_value;
    logic                      from_stack;
    logic                      last;

    modport source (output valid, output status, output out_value, output from_stack,
                    output last, input ready);
    modport sink   (input valid, input status, input out_value, input from_stack,
                    input last, output ready);
endinterface

FILE: hdl/queue_stack_transfer_engine.sv
// top level: fifo queue and lifo stack in two memories with transfer and dump sequencing
//
//  channel  dir  modport      payload
//  i_in     in   sink         func, data_value
//  o_out    out  source       status, out_value, from_stack, last
//
//  enqueue, push, ignored codes and empty dequeue, pop or dump finish straight from idle;
//  dequeue and pop of a stored word wait in a read state for the registered memory read data
//  transfer moves words through S_XFER then reports from S_EMIT; dump lists words in S_DUMP
//  reset clears pointers, counts, dump state and the output valid flag; memories need no clearing pass
//  a finished result waits in the output register; a new operation is taken only in idle
//  while that register is empty or being drained, dump reads pause while it stalls
module queue_stack_transfer_engine import qst_pkg::*; #(
    parameter int QUEUE_DEPTH = 32,
    parameter int STACK_DEPTH = 32,
    parameter int DATA_WIDTH  = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    qst_in_if.sink         i_in,
    qst_out_if.source      o_out
);

    localparam int QAW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SCW = $clog2(STACK_DEPTH + 1);
    localparam int XW  = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;
    localparam int TW  = $clog2(QUEUE_DEPTH + STACK_DEPTH + 2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDQ,
        S_RDS,
        S_XFER,
        S_EMIT,
        S_DUMP
    } t_state;

    // circular queue index wrap, sum is always below twice the depth
    function automatic logic [QAW-1:0] f_wrap(input logic [QAW:0] s);
        logic [QAW:0] d;
        d = (QAW+1)'(QUEUE_DEPTH);
        if (s >= d) begin
            f_wrap = QAW'(s - d);
        end else begin
            f_wrap = s[QAW-1:0];
        end
    endfunction

    // stored word to result value, zero extended or cut to the port width
    function automatic logic [VALUE_W-1:0] f_out(input logic [DATA_WIDTH-1:0] w);
        logic [XW-1:0] x;
        x = XW'(w);
        f_out = x[VALUE_W-1:0];
    endfunction

    // incoming word to stored width
    function automatic logic [DATA_WIDTH-1:0] f_in(input logic [VALUE_W-1:0] v);
        logic [XW-1:0] x;
        x = XW'(v);
        f_in = x[DATA_WIDTH-1:0];
    endfunction

    // control registers
    t_state           r_state, n_state;
    logic [QAW-1:0]   r_qhead, n_qhead;
    logic [QCW-1:0]   r_qcount, n_qcount;
    logic [SCW-1:0]   r_scount, n_scount;
    logic             r_pend, n_pend;       // transfer word read, waiting to be written
    logic [QCW-1:0]   r_qi, n_qi;           // dump walk through the queue
    logic [SCW-1:0]   r_si, n_si;           // dump walk down the stack
    logic             r_rdv, n_rdv;         // dump read data waiting
    logic             r_rdstk, n_rdstk;
    logic             r_rdlast, n_rdlast;
    logic             r_out_valid, n_out_valid;
    // payload registers
    t_result          r_out, n_out;
    t_result          r_res, n_res;

    // memory ports
    logic                  q_we, q_re, s_we, s_re;
    logic [QAW-1:0]        q_waddr, q_raddr;
    logic [SAW-1:0]        s_waddr, s_raddr;
    logic [DATA_WIDTH-1:0] q_wdata, s_wdata, q_rdata, s_rdata;

    logic           out_free;
    logic           in_ready;
    logic           acc;
    logic [QAW-1:0] q_tail;
    logic           q_full, q_empty, s_full, s_empty;
    logic           can_rd, more_q, more_s;
    logic [TW-1:0]  w_held;

    qst_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(DATA_WIDTH)) u_qram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (q_waddr),
        .i_wdata (q_wdata),
        .i_re    (q_re),
        .i_raddr (q_raddr),
        .o_rdata (q_rdata)
    );

    qst_ram #(.DEPTH(STACK_DEPTH), .WIDTH(DATA_WIDTH)) u_sram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_re    (s_re),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    // output register is free when empty or drained at this edge
    assign out_free = !r_out_valid || o_out.ready;
    assign in_ready = (r_state == S_IDLE) && out_free;
    assign acc      = i_in.valid && in_ready;

    assign q_tail  = f_wrap({1'b0, r_qhead} + (QAW+1)'(r_qcount));
    assign q_full  = (r_qcount == QCW'(QUEUE_DEPTH));
    assign q_empty = (r_qcount == '0);
    assign s_full  = (r_scount == SCW'(STACK_DEPTH));
    assign s_empty = (r_scount == '0);

    assign can_rd = !r_rdv || out_free;
    assign more_q = (r_qi != r_qcount);
    assign more_s = (r_si != '0);

    always_comb begin
        n_state     = r_state;
        n_qhead     = r_qhead;
        n_qcount    = r_qcount;
        n_scount    = r_scount;
        n_pend      = r_pend;
        n_qi        = r_qi;
        n_si        = r_si;
        n_rdv       = r_rdv;
        n_rdstk     = r_rdstk;
        n_rdlast    = r_rdlast;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out       = r_out;
        n_res       = r_res;

        q_we    = 1'b0;
        q_waddr = q_tail;
        q_wdata = f_in(i_in.data_value);
        q_re    = 1'b0;
        q_raddr = r_qhead;
        s_we    = 1'b0;
        s_waddr = r_scount[SAW-1:0];
        s_wdata = f_in(i_in.data_value);
        s_re    = 1'b0;
        s_raddr = SAW'(r_scount - 1'b1);

        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (i_in.func)
                        FN_ENQ: begin
                            n_out_valid = 1'b1;
                            n_out       = '{ST_OK, '0, 1'b0, 1'b1};
                            if (q_full) begin
                                n_out.status = ST_FULL;
                            end else begin
                                q_we     = 1'b1;
                                n_qcount = r_qcount + 1'b1;
                            end
                        end
                        FN_DEQ: begin
                            if (q_empty) begin
                                n_out_valid = 1'b1;
                                n_out       = '{ST_EMPTY, '0, 1'b0, 1'b1};
                            end else begin
                                q_re     = 1'b1;
                                n_qhead  = f_wrap({1'b0, r_qhead} + 1'b1);
                                n_qcount = r_qcount - 1'b1;
                                n_state  = S_RDQ;
                            end
                        end
                        FN_PUSH: begin
                            n_out_valid = 1'b1;
                            n_out       = '{ST_OK, '0, 1'b1, 1'b1};
                            if (s_full) begin
                                n_out.status = ST_FULL;
                            end else begin
                                s_we     = 1'b1;
                                n_scount = r_scount + 1'b1;
                            end
                        end
                        FN_POP: begin
                            if (s_empty) begin
                                n_out_valid = 1'b1;
                                n_out       = '{ST_EMPTY, '0, 1'b1, 1'b1};
                            end else begin
                                s_re     = 1'b1;
                                n_scount = r_scount - 1'b1;
                                n_state  = S_RDS;
                            end
                        end
                        FN_XFER: begin
                            n_pend  = 1'b0;
                            n_state = S_XFER;
                        end
                        FN_DUMP: begin
                            if (q_empty && s_empty) begin
                                n_out_valid = 1'b1;
                                n_out       = '{ST_EMPTY, '0, 1'b0, 1'b1};
                            end else begin
                                n_qi    = '0;
                                n_si    = r_scount;
                                n_rdv   = 1'b0;
                                n_state = S_DUMP;
                            end
                        end
                        default: begin
                            // unused codes are taken and dropped without a result
                        end
                    endcase
                end
            end
            S_RDQ: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{ST_OK, f_out(q_rdata), 1'b0, 1'b1};
                    n_state     = S_IDLE;
                end
            end
            S_RDS: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{ST_OK, f_out(s_rdata), 1'b1, 1'b1};
                    n_state     = S_IDLE;
                end
            end
            S_XFER: begin
                // write the word read last cycle while reading the next stack top
                q_wdata = s_rdata;
                if (r_pend) begin
                    q_we     = 1'b1;
                    n_qcount = r_qcount + 1'b1;
                end
                if (!s_empty && ((QCW+1)'(r_qcount) + (QCW+1)'(r_pend))
                        < (QCW+1)'(QUEUE_DEPTH)) begin
                    s_re     = 1'b1;
                    n_scount = r_scount - 1'b1;
                    n_pend   = 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_res   = '{ST_OK, '0, 1'b0, 1'b1};
                    if (!s_empty) begin
                        n_res.status = ST_FULL;
                    end
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            S_DUMP: begin
                // hand the waiting word to the output register
                if (r_rdv && out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{ST_OK, f_out(r_rdstk ? s_rdata : q_rdata), r_rdstk,
                                    r_rdlast};
                end
                q_raddr = f_wrap({1'b0, r_qhead} + (QAW+1)'(r_qi));
                s_raddr = SAW'(r_si - 1'b1);
                if (can_rd) begin
                    if (more_q) begin
                        q_re     = 1'b1;
                        n_qi     = r_qi + 1'b1;
                        n_rdv    = 1'b1;
                        n_rdstk  = 1'b0;
                        n_rdlast = (QCW'(r_qi + 1'b1) == r_qcount) && s_empty;
                    end else if (more_s) begin
                        s_re     = 1'b1;
                        n_si     = r_si - 1'b1;
                        n_rdv    = 1'b1;
                        n_rdstk  = 1'b1;
                        n_rdlast = (r_si == SCW'(1));
                    end else begin
                        n_rdv   = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_qhead     <= '0;
            r_qcount    <= '0;
            r_scount    <= '0;
            r_pend      <= 1'b0;
            r_qi        <= '0;
            r_si        <= '0;
            r_rdv       <= 1'b0;
            r_rdstk     <= 1'b0;
            r_rdlast    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_qhead     <= n_qhead;
            r_qcount    <= n_qcount;
            r_scount    <= n_scount;
            r_pend      <= n_pend;
            r_qi        <= n_qi;
            r_si        <= n_si;
            r_rdv       <= n_rdv;
            r_rdstk     <= n_rdstk;
            r_rdlast    <= n_rdlast;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
        r_res <= n_res;
    end

    assign i_in.ready       = in_ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_out.status;
    assign o_out.out_value  = $signed(r_out.value);
    assign o_out.from_stack = r_out.from_stack;
    assign o_out.last       = r_out.last;

    // words held in both stores plus the one in flight during a transfer
    assign w_held = TW'(r_qcount) + TW'(r_scount) + TW'(r_pend);

    // counts never pass their depths
    a_qcount_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcount <= QCW'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_scount_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scount <= SCW'(STACK_DEPTH))
        else $error("stack count above depth");

    // a transfer moves words, it neither loses nor creates them
    a_xfer_conserve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_XFER) |=> (w_held == $past(w_held)))
        else $error("transfer changed the number of held words");

    // dump leaves both stores untouched
    a_dump_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) |=> ($stable(r_qcount) && $stable(r_scount)
                                 && $stable(r_qhead)))
        else $error("dump modified a store");

endmodule

FILE: hdl/qst_ram.sv
// single write port, single read port memory with registered read data
module qst_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
